// ===== design/hdfi_pkg.sv =====
`timescale 1ns / 1ps
package hdfi_pkg;
    localparam int MAX_BUCKETS = 1024;
    localparam int CAPACITY    = 1024;
    localparam int KEY_BITS    = 32;
    localparam int BKT_W  = $clog2(MAX_BUCKETS);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int PTR_W  = IDX_W + 1;
    localparam int CFG_W  = 11;
    localparam int HASH_W = 32;
    localparam logic [PTR_W-1:0] NO_ENTRY = PTR_W'(CAPACITY);
    localparam logic [CFG_W-1:0] BUCKETS_RESET = CFG_W'(256);

    typedef struct packed {
        logic        req_type;
        logic [31:0] key;
        logic [31:0] key_hash;
    } req_t;

    typedef struct packed {
        logic       found;
        logic       inserted;
        logic [9:0] slot_index;
        logic       full_res;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, begin modulo
        logic mod_step;   // one restoring-division step
        logic head_rd;    // read bucket head
        logic ent_rd;     // read entry at cursor
        logic cur_head;   // cursor <- head read data
        logic cur_next;   // cursor <- next read data
        logic do_insert;  // write entry, head, bump fill count
        logic emit;       // drive result strobe
        logic set_found;
        logic set_full;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mod_done;
        logic cur_valid;  // cursor points at a used entry
        logic key_match;
        logic is_get;
        logic cap_full;
    } sts_t;
endpackage

// ===== design/hdfi_ram.sv =====
`timescale 1ns / 1ps
module hdfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== design/hdfi_ctrl.sv =====
`timescale 1ns / 1ps
module hdfi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          clr_done,
    input  hdfi_pkg::sts_t sts,
    output hdfi_pkg::cmd_t cmd,
    output logic          busy
);
    import hdfi_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_HEAD = 3'd3;
    localparam logic [2:0] S_HCAP = 3'd4;
    localparam logic [2:0] S_ENT  = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    cmd.head_rd = 1'b1;
                    state_next = S_HEAD;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_HEAD:
            begin
                cmd.cur_head = 1'b1;
                state_next = S_HCAP;
            end
            S_HCAP, S_CMP:
            begin
                // S_CMP: entry data present; S_HCAP: cursor fresh
                if (state_reg == S_CMP && sts.key_match)
                begin
                    cmd.emit = 1'b1;
                    cmd.set_found = 1'b1;
                    state_next = S_IDLE;
                end
                else if (state_reg == S_CMP)
                begin
                    cmd.cur_next = 1'b1;
                    state_next = S_HCAP;
                end
                else if (sts.cur_valid)
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_ENT;
                end
                else
                begin
                    cmd.emit = 1'b1;
                    if (sts.is_get)
                    begin
                        if (sts.cap_full)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else
                        begin
                            cmd.do_insert = 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_ENT:
            begin
                state_next = S_CMP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !busy) else $error("result without return to idle");
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.set_found && (cmd.do_insert || cmd.set_full)))
        else $error("conflicting outcome");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_MOD) else $error("load did not start modulo");
endmodule

// ===== design/hdfi_dp.sv =====
`timescale 1ns / 1ps
module hdfi_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [hdfi_pkg::CFG_W-1:0] cfg_data,
    input  hdfi_pkg::req_t             req,
    input  hdfi_pkg::cmd_t             cmd,
    output hdfi_pkg::sts_t             sts,
    output logic                       clr_done,
    output logic                       done,
    output hdfi_pkg::res_t             result
);
    import hdfi_pkg::*;

    logic [CFG_W-1:0]  bcount_reg;
    logic [BKT_W:0]    div_val;      // effective bucket count
    logic [KEY_BITS-1:0] key_reg;
    logic              get_reg;
    logic [HASH_W-1:0] quo_reg;      // hash bits shifted out
    logic [BKT_W+1:0]  rem_reg;
    logic [5:0]        step_reg;
    logic [PTR_W-1:0]  cur_reg, used_reg;
    logic [PTR_W-1:0]  head_reg;     // bucket head seen at the start of the walk
    logic [BKT_W-1:0]  bkt_reg;
    logic              clr_reg;
    logic [BKT_W-1:0]  clr_addr_reg;
    logic [PTR_W-1:0]  head_rdata, next_rdata;
    logic [KEY_BITS-1:0] key_rdata;
    logic [BKT_W+1:0]  rem_sh;
    logic              head_we;
    logic [BKT_W-1:0]  head_waddr;
    logic [PTR_W-1:0]  head_wdata;
    logic              done_reg;
    res_t              res_reg;

    always_comb
    begin
        if (bcount_reg == '0)
        begin
            div_val = (BKT_W+1)'(1);
        end
        else if (bcount_reg > CFG_W'(MAX_BUCKETS))
        begin
            div_val = (BKT_W+1)'(MAX_BUCKETS);
        end
        else
        begin
            div_val = (BKT_W+1)'(bcount_reg);
        end
    end

    assign rem_sh = {rem_reg[BKT_W:0], quo_reg[HASH_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg   <= BUCKETS_RESET;
            used_reg     <= '0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bcount_reg <= cfg_data;
            end
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == BKT_W'(MAX_BUCKETS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (cmd.do_insert)
            begin
                used_reg <= used_reg + 1'b1;
            end
            done_reg <= cmd.emit;
        end
    end

    // restoring division: one hash bit a step, keep remainder only
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= req.key;
            get_reg  <= req.req_type;
            quo_reg  <= req.key_hash;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            quo_reg  <= {quo_reg[HASH_W-2:0], 1'b0};
            step_reg <= step_reg + 1'b1;
            if (rem_sh >= (BKT_W+2)'(div_val))
            begin
                rem_reg <= rem_sh - (BKT_W+2)'(div_val);
            end
            else
            begin
                rem_reg <= rem_sh;
            end
        end
        if (cmd.head_rd)
        begin
            bkt_reg <= rem_reg[BKT_W-1:0];
        end
        if (cmd.cur_head)
        begin
            cur_reg  <= head_rdata;
            head_reg <= head_rdata;
        end
        else if (cmd.cur_next)
        begin
            cur_reg <= next_rdata;
        end
        if (cmd.emit)
        begin
            res_reg.found      <= cmd.set_found;
            res_reg.inserted   <= cmd.do_insert;
            res_reg.full_res   <= cmd.set_full;
            res_reg.slot_index <= cmd.set_found ? cur_reg[IDX_W-1:0] :
                                  cmd.do_insert ? used_reg[IDX_W-1:0] : '0;
        end
    end

    assign sts.mod_done  = (step_reg == 6'(HASH_W));
    assign sts.cur_valid = (cur_reg < used_reg);
    assign sts.key_match = (key_rdata == key_reg);
    assign sts.is_get    = get_reg;
    assign sts.cap_full  = (used_reg == PTR_W'(CAPACITY));
    assign clr_done      = !clr_reg;
    assign done          = done_reg;
    assign result        = res_reg;

    assign head_we    = clr_reg || cmd.do_insert;
    assign head_waddr = clr_reg ? clr_addr_reg : bkt_reg;
    assign head_wdata = clr_reg ? NO_ENTRY : used_reg;

    hdfi_ram #(.WIDTH(PTR_W), .DEPTH(MAX_BUCKETS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(cmd.head_rd), .raddr(rem_reg[BKT_W-1:0]), .rdata(head_rdata));

    hdfi_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
        .clk(clk), .we(cmd.do_insert), .waddr(used_reg[IDX_W-1:0]),
        .wdata(key_reg), .re(cmd.ent_rd), .raddr(cur_reg[IDX_W-1:0]),
        .rdata(key_rdata));

    // new entry links to the old bucket head
    hdfi_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .we(cmd.do_insert), .waddr(used_reg[IDX_W-1:0]),
        .wdata(head_reg), .re(cmd.ent_rd), .raddr(cur_reg[IDX_W-1:0]),
        .rdata(next_rdata));

    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= PTR_W'(CAPACITY)) else $error("fill count overflow");
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |-> !sts.cap_full) else $error("insert into full table");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.head_rd |-> rem_reg < (BKT_W+2)'(div_val)) else $error("bad remainder");
endmodule

// ===== design/hash_dict_find_or_insert.sv =====
`timescale 1ns / 1ps
// Hash dictionary: maps keys to dense slot indices via chained buckets.
// Request: pulse start with req (req_type, key, key_hash) while busy is
//   low; the beat is taken on that edge and busy rises at once.
// Result: done is high for exactly one cycle with result (found,
//   inserted, slot_index, full_res); the receiver cannot stall it.
// Flow: the bit-serial modulo unit takes one hash bit per cycle, then a
//   finishing step; then come the bucket head read and the cursor load;
//   each chain entry visited takes a memory read, a compare and a follow;
//   the result register then drives done. Busy is low again in the done
//   cycle; one request at a time.
// Config: cfg_we/cfg_data write bucket_count (0 means 1, above 1024
//   saturates); write only while busy is low.
// Reset: bucket_count returns to 256, the fill count to zero, and a
//   clearing pass over all 1024 bucket heads empties them; busy stays
//   high until it ends. Entry key and link memories are never cleared:
//   chains only reach entries below the fill count.
module hash_dict_find_or_insert (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  hdfi_pkg::req_t             req,
    output logic                       done,
    output hdfi_pkg::res_t             result,
    input  logic                       cfg_we,
    input  logic [hdfi_pkg::CFG_W-1:0] cfg_data
);
    import hdfi_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic clr_done;

    // sequence each request: modulo, head read, chain walk, insert
    hdfi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .clr_done(clr_done),
        .sts(sts), .cmd(cmd), .busy(busy));

    // hold registers, memories and the divider
    hdfi_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .req(req), .cmd(cmd), .sts(sts), .clr_done(clr_done),
        .done(done), .result(result));

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted beat not held busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $countones({result.found, result.inserted, result.full_res}) <= 1)
        else $error("result flags overlap");
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import hdfi_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 3500;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t result;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_data;

    hash_dict_find_or_insert i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the dictionary, used to predict each lookup.
    logic [CFG_W-1:0] shadow_buckets;
    logic [PTR_W-1:0] shadow_head [MAX_BUCKETS];
    logic [31:0]      shadow_key  [CAPACITY];
    logic [PTR_W-1:0] shadow_next [CAPACITY];
    int unsigned      shadow_used;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int   sender_idle_pct;
    int   errors;
    int   quiet_cycles;
    bit   stim_done;
    logic accepted_last;

    function automatic res_t lookup_and_insert(req_t r);
        res_t        o;
        int unsigned nb;
        int unsigned b;
        int unsigned cur;
        int unsigned steps;
        o = '0;
        nb = (shadow_buckets == 0) ? 1 :
             (shadow_buckets > MAX_BUCKETS) ? MAX_BUCKETS : shadow_buckets;
        b = r.key_hash % nb;
        cur = shadow_head[b];
        steps = 0;
        // Walk the chain newest first; stop at any link past the fill count.
        while (cur < shadow_used && cur < CAPACITY && steps < CAPACITY)
        begin
            if (shadow_key[cur] == r.key)
            begin
                o.found = 1'b1;
                o.slot_index = cur[9:0];
                break;
            end
            cur = shadow_next[cur];
            steps++;
        end
        if (!o.found && r.req_type)
        begin
            if (shadow_used >= CAPACITY)
                o.full_res = 1'b1;
            else
            begin
                shadow_key[shadow_used]  = r.key;
                shadow_next[shadow_used] = shadow_head[b];
                shadow_head[b]           = shadow_used[PTR_W-1:0];
                o.inserted   = 1'b1;
                o.slot_index = shadow_used[9:0];
                shadow_used++;
            end
        end
        return o;
    endfunction

    // Driver: present the next pending beat at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || accepted_last)
            begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    req   <= pending_reqs.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                    req   <= {$urandom, $urandom, $urandom};
                end
            end
        end
    end

    // Monitor: predict on each accepted beat, check each result strobe.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_last <= 1'b0;
            quiet_cycles  <= 0;
        end
        else
        begin
            res_t exp_res;
            accepted_last <= start && !busy;
            if (start && !busy)
                expected_results.push_back(lookup_and_insert(req));
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    errors++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result.found !== exp_res.found)
                    begin
                        $error("found: expected %0d got %0d", exp_res.found, result.found);
                        errors++;
                    end
                    if (result.inserted !== exp_res.inserted)
                    begin
                        $error("inserted: expected %0d got %0d",
                               exp_res.inserted, result.inserted);
                        errors++;
                    end
                    if (result.slot_index !== exp_res.slot_index)
                    begin
                        $error("slot_index: expected %0d got %0d",
                               exp_res.slot_index, result.slot_index);
                        errors++;
                    end
                    if (result.full_res !== exp_res.full_res)
                    begin
                        $error("full_res: expected %0d got %0d",
                               exp_res.full_res, result.full_res);
                        errors++;
                    end
                end
            end
            // Watchdog: count cycles in which no beat moves either way.
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_buckets(logic [CFG_W-1:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        shadow_buckets = v;
    endtask

    function automatic req_t make_req(bit get, logic [31:0] k, logic [31:0] h);
        req_t r;
        r.req_type = get;
        r.key      = k;
        r.key_hash = h;
        return r;
    endfunction

    // Mostly inserts and lookups drawn from a small key pool, so chains
    // build up and repeat keys hit; the rest is raw noise.
    task automatic queue_random(int n, int pool);
        logic [31:0] k;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9, 0) < 8)
            begin
                k = $urandom_range(pool - 1, 0) * 32'h9E37_79B1;
                pending_reqs.push_back(make_req($urandom_range(1, 0), k,
                                                k ^ (k >> 7)));
            end
            else
                pending_reqs.push_back(make_req($urandom_range(1, 0), $urandom, $urandom));
        end
    endtask

    initial
    begin
        errors = 0;
        stim_done = 1'b0;
        sender_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        shadow_buckets = BUCKETS_RESET;
        shadow_used = 0;
        for (int i = 0; i < MAX_BUCKETS; i++)
            shadow_head[i] = NO_ENTRY;
        for (int i = 0; i < CAPACITY; i++)
        begin
            shadow_key[i]  = '0;
            shadow_next[i] = NO_ENTRY;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: misses, inserts, hits, extreme fields, collisions.
        pending_reqs.push_back(make_req(1'b0, 32'h0, 32'h0));
        pending_reqs.push_back(make_req(1'b1, 32'h0, 32'h0));
        pending_reqs.push_back(make_req(1'b0, 32'h0, 32'h0));
        pending_reqs.push_back(make_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(1'b1, 32'h1234_5678, 32'h0000_0100));
        pending_reqs.push_back(make_req(1'b1, 32'h8765_4321, 32'h0000_0200));
        pending_reqs.push_back(make_req(1'b0, 32'h1234_5678, 32'h0000_0100));
        pending_reqs.push_back(make_req(1'b0, 32'h8765_4321, 32'h0000_0000));
        pending_reqs.push_back(make_req(1'b0, 32'hAAAA_5555, 32'h5555_AAAA));
        wait_drained();

        // One bucket: everything lands on one chain.
        write_buckets(11'd0);
        queue_random(40, 30);
        write_buckets(11'd1);
        queue_random(40, 30);
        // Above the maximum saturates; then the maximum itself.
        write_buckets(11'h7FF);
        queue_random(60, 200);
        write_buckets(11'd1024);
        sender_idle_pct = 84;
        queue_random(120, 200);
        write_buckets(11'd7);
        sender_idle_pct = 16;
        queue_random(150, 100);
        write_buckets(11'd1025);
        sender_idle_pct = 0;
        // Spread keys over a wide pool, then return to the reset divisor.
        queue_random(200, 4000);
        write_buckets(BUCKETS_RESET);
        sender_idle_pct = 84;
        queue_random(40, 4000);
        sender_idle_pct = 0;
        queue_random(40, 4000);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
design/hdfi_pkg.sv
design/hdfi_ram.sv
design/hdfi_ctrl.sv
design/hdfi_dp.sv
design/hash_dict_find_or_insert.sv
verif/tb_top.sv
